/* rtl/chc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading package
// Shared constants for the compass heading block.
// ----------------------------------------------------------------------------
package chc_pkg;
  localparam int AXIS_WIDTH_DEF = 16;
  localparam int FIELD_WIDTH = 16;
  localparam int IN_DATA_WIDTH = 48;
  localparam int OUT_DATA_WIDTH = 16;
  localparam logic [15:0] OFFS_0 = 16'd0;
  localparam logic [15:0] OFFS_90 = 16'd9000;
  localparam logic [15:0] OFFS_180 = 16'd18000;
  localparam logic [15:0] OFFS_270 = 16'd27000;
  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [10:0] COEF_LIN = 11'd1402;
  localparam logic [8:0] COEF_CUB = 9'd379;
  localparam logic [12:0] COEF_45 = 13'd4500;
endpackage

/* rtl/chc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chc_divider #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic [$clog2(W+1)-1:0] cnt;
  logic [W:0] trial;

  assign trial = {rem[W-1:0], quotient[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= ($clog2(W+1))'(W);
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == ($clog2(W+1))'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

/* rtl/compass_heading_with_calibration_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compass heading with hard-iron calibration
// Tracks per-axis extremes, calibrates a sample and returns its heading.
// ----------------------------------------------------------------------------
// Usage: one item on s_axis carries x_raw, y_raw and z_raw. Each produces
// exactly one item on m_axis with the heading in hundredths of a degree and
// a valid flag in tuser.
// One item is worked on at a time. The work runs through a bit-serial
// divider of 40 steps, used twice (for the calibration scale and for the
// octant ratio), and the multiply steps S_P1, S_P2 and S_MAG. An item whose
// sum of maxima is not positive skips both divisions, and one whose
// calibrated vector is zero skips the octant division and the multiply steps.
// A new item is accepted once the previous result has been moved into the
// output register, so a stalled receiver holds the result and stops input
// only when a second result would be ready.
// Reset clears the axis extremes to zero and empties the output register.
// ----------------------------------------------------------------------------
module compass_heading_with_calibration_top #(
  parameter int AXIS_WIDTH = chc_pkg::AXIS_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [chc_pkg::IN_DATA_WIDTH-1:0] s_axis_tdata,  // x_raw, y_raw, z_raw
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [chc_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata, // heading_centideg
  output logic                             m_axis_tuser   // heading_valid
);
  import chc_pkg::*;

  localparam int AW = AXIS_WIDTH;
  localparam int DW = 40;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SUM   = 11'b00000000010,
    S_SDIV  = 11'b00000000100,
    S_CALX  = 11'b00000001000,
    S_CALY  = 11'b00000010000,
    S_OCT   = 11'b00000100000,
    S_VDIV  = 11'b00001000000,
    S_P1    = 11'b00010000000,
    S_P2    = 11'b00100000000,
    S_MAG   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;
  logic signed [AW-1:0] x_max, x_min, y_max, y_min, z_max, z_min;
  logic signed [AW-1:0] rx, ry;
  logic [17:0] scale;
  logic signed [AW-1:0] cx, cy;
  logic [15:0] offs;
  logic vneg;
  logic [16:0] a;
  logic [26:0] coef;
  logic [44:0] tval;
  logic [61:0] mag;
  logic calc_ok;
  logic [15:0] res_head;
  logic res_valid;
  logic res_full;

  logic div_start, div_busy, div_busy_q;
  logic [DW-1:0] div_a, div_b, div_q;

  chc_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  logic signed [AW-1:0] in_x, in_y, in_z;
  assign in_x = s_axis_tdata[AW-1:0];
  assign in_y = s_axis_tdata[FIELD_WIDTH+AW-1:FIELD_WIDTH];
  assign in_z = s_axis_tdata[2*FIELD_WIDTH+AW-1:2*FIELD_WIDTH];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = res_full;
  assign m_axis_tdata = res_head;
  assign m_axis_tuser = res_valid;

  function automatic logic signed [AW-1:0] calib(input logic signed [AW-1:0] s,
      input logic signed [AW-1:0] mn, input logic signed [AW-1:0] mx,
      input logic [17:0] sc);
    logic signed [AW:0] tot;
    logic signed [AW:0] off;
    logic signed [AW+1:0] d;
    logic signed [AW+20:0] p;
    logic signed [AW+20:0] q;
    tot = (AW+1)'(mx) + (AW+1)'(mn);
    off = (tot < 0) ? -((-tot) >>> 1) : (tot >>> 1);
    d = (AW+2)'(s) - (AW+2)'(off);
    p = (AW+21)'(d) * $signed({1'b0, sc});
    q = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
    if (q > (AW+21)'((1 <<< (AW-1)) - 1)) calib = {1'b0, {(AW-1){1'b1}}};
    else if (q < -(AW+21)'(1 <<< (AW-1))) calib = {1'b1, {(AW-1){1'b0}}};
    else calib = q[AW-1:0];
  endfunction

  logic signed [AW:0] ax, ay, num, den;
  logic [AW:0] anum, aden;
  logic [AW:0] cxe, cye;
  assign cxe = (AW+1)'(cx);
  assign cye = (AW+1)'(cy);

  logic [15:0] cd;
  logic signed [17:0] hsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      x_max <= '0; x_min <= '0; y_max <= '0; y_min <= '0;
      z_max <= '0; z_min <= '0;
      res_full <= 1'b0;
      div_start <= 1'b0;
      div_busy_q <= 1'b0;
    end else begin
      div_busy_q <= div_busy;
      div_start <= 1'b0;
      if ((state == S_DONE) && (!res_full || m_axis_tready)) begin
        res_full <= 1'b1;
      end else if (m_axis_tready) begin
        res_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            rx <= in_x; ry <= in_y;
            calc_ok <= 1'b1;
            if (in_x < x_min) x_min <= in_x; else if (in_x > x_max) x_max <= in_x;
            if (in_y < y_min) y_min <= in_y; else if (in_y > y_max) y_max <= in_y;
            if (in_z < z_min) z_min <= in_z; else if (in_z > z_max) z_max <= in_z;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          div_a <= (DW'({2'b0, x_max}) * DW'(3)) << 16;
          div_b <= DW'((AW+2)'(x_max) + (AW+2)'(y_max) + (AW+2)'(z_max));
          if ((AW+2)'(x_max) + (AW+2)'(y_max) + (AW+2)'(z_max) <= 0) begin
            calc_ok <= 1'b0;
            state <= S_DONE;
          end else begin
            div_start <= 1'b1;
            state <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_busy_q && !div_busy) begin
            scale <= div_q[17:0];
            state <= S_CALX;
          end
        end
        S_CALX: begin
          cx <= calib(rx, x_min, x_max, scale);
          cy <= calib(ry, y_min, y_max, scale);
          state <= S_CALY;
        end
        S_CALY: begin
          if (cx == 0 && cy == 0) begin
            calc_ok <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_OCT;
          end
        end
        S_OCT: begin
          vneg <= num[AW] ^ den[AW];
          div_a <= DW'(anum) << 16;
          div_b <= DW'(aden);
          div_start <= 1'b1;
          state <= S_VDIV;
        end
        S_VDIV: begin
          if (div_busy_q && !div_busy) begin
            a <= div_q[16:0];
            state <= S_P1;
          end
        end
        S_P1: begin
          coef <= {COEF_LIN, 16'b0} + 27'(COEF_CUB) * 27'(a);
          state <= S_P2;
        end
        S_P2: begin
          tval <= {COEF_45, 32'b0} + 45'(17'd65536 - a) * 45'(coef);
          state <= S_MAG;
        end
        S_MAG: begin
          mag <= 62'(a) * 62'(tval);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_full || m_axis_tready) begin
            res_head <= calc_ok ? hsum[15:0] : 16'd0;
            res_valid <= calc_ok && (hsum != 0);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ax = cx[AW-1] ? -(AW+1)'(cx) : (AW+1)'(cx);
    ay = cy[AW-1] ? -(AW+1)'(cy) : (AW+1)'(cy);
    if (!cx[AW-1]) begin
      if (ay > $signed(cxe)) begin
        if (cy[AW-1]) begin offs = OFFS_270; num = -$signed(cxe); den = $signed(cye); end
        else begin offs = OFFS_90; num = $signed(cxe); den = -$signed(cye); end
      end else begin
        offs = OFFS_0; num = $signed(cye); den = $signed(cxe);
      end
    end else begin
      if ($signed(cye) > ax) begin offs = OFFS_90; num = $signed(cxe); den = -$signed(cye); end
      else if (ay > ax) begin offs = OFFS_270; num = -$signed(cxe); den = $signed(cye); end
      else begin offs = OFFS_180; num = -$signed(cye); den = -$signed(cxe); end
    end
    anum = num[AW] ? -num : num;
    aden = den[AW] ? -den : den;
    cd = 16'((mag + (62'd1 << 47)) >> 48);
    if (vneg) hsum = $signed({2'b00, offs}) - $signed({2'b00, cd});
    else hsum = $signed({2'b00, offs}) + $signed({2'b00, cd});
    if (hsum < 0) hsum = hsum + $signed({2'b00, FULL_TURN});
    if (hsum >= $signed({2'b00, FULL_TURN})) hsum = hsum - $signed({2'b00, FULL_TURN});
  end

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata < FULL_TURN))
    else $error("heading out of range");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("invalid heading not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
endmodule
